// ===== hdl/brr_adpcm_block_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// BRR decoder assertion macros
// Shared concurrent assertion forms, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BRR_ADPCM_BLOCK_DECODER_DEFINES_SVH
`define BRR_ADPCM_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication
`define BRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/brr_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// BRR decoder package
// Shared types, register indexes and constants of the BRR block decoder.
// ----------------------------------------------------------------------------
package brr_dec_pkg;

    localparam int unsigned SAMPLES     = 16;
    localparam int unsigned IDX_W       = $clog2(SAMPLES);
    localparam int unsigned NUM_BYTES   = 8;
    localparam int unsigned IN_TDATA_W  = 8 * (NUM_BYTES + 1);
    localparam int unsigned QUEUE_DEPTH = 2;   // power of two
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_P1_MUL_F1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_MUL_F2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_MUL_F3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_SH_F1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_SH_F2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_SH_F3  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_P2_MUL_F2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_P2_MUL_F3 = 3'd7;

    localparam logic [1:0] FILT_NONE = 2'd0;
    localparam logic [1:0] FILT_1    = 2'd1;
    localparam logic [1:0] FILT_2    = 2'd2;
    localparam logic [1:0] FILT_3    = 2'd3;

    localparam int unsigned HDR_END_BIT  = 0;
    localparam int unsigned HDR_LOOP_BIT = 1;

    localparam int unsigned USER_END  = 0;
    localparam int unsigned USER_LOOP = 1;

    localparam int unsigned PRED2_SHIFT = 4;

    localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN = 16'sh8000;

    typedef struct packed {
        logic [7:0] p1_mul_f1;
        logic [7:0] p1_mul_f2;
        logic [7:0] p1_mul_f3;
        logic [3:0] p1_sh_f1;
        logic [3:0] p1_sh_f2;
        logic [3:0] p1_sh_f3;
        logic [7:0] p2_mul_f2;
        logic [7:0] p2_mul_f3;
    } t_cfg;

    typedef struct packed {
        logic                          start;
        logic [7:0]                    header;
        logic [NUM_BYTES-1:0][7:0]     data;
    } t_blk;

    typedef struct packed {
        logic valid;
        t_blk blk;
    } t_push;

endpackage

// ===== hdl/brr_adpcm_block_decoder.sv =====
// ----------------------------------------------------------------------------
// BRR ADPCM block decoder
// Top level: configuration registers, front end, block queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 9-byte BRR block per item; tuser[0] starts a new
//   stream (clears history and the finished flag before the block).
//   m_axis carries one 16-bit PCM sample per item; tlast marks the 16th
//   sample of a block, tuser flags end of stream and loop on that sample.
//   Blocks that follow an end-flagged block are dropped without output
//   until one arrives with a stream start.
//   With the back end idle, the first sample of a block passes the queue
//   write, block load and output register to m_axis. Throughput: one
//   sample per cycle while m_axis does not stall; each sample needs the
//   previous one through the single predictor/clamp datapath.
//   A two-entry queue lets the front keep taking blocks while the back works.
//   When m_axis stalls the output register holds and the back end freezes;
//   once the queue is full s_axis_tready drops. Reset clears history,
//   finished flag and queue and loads the default predictor coefficients.
//   Config writes go through i_cfg_we while idle (user's duty; not enforced).
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [brr_dec_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [brr_dec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // block_header, data_byte_0 .. data_byte_7
    input  logic [brr_dec_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // stream_start
    input  logic [0:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pcm_sample
    output logic [15:0]                            m_axis_tdata,
    output logic                                   m_axis_tlast,
    // end_of_stream, loop_flag
    output logic [1:0]                             m_axis_tuser
);

    brr_dec_pkg::t_cfg  r_cfg, n_cfg;
    brr_dec_pkg::t_push w_push;
    brr_dec_pkg::t_blk  w_qblk;
    logic               w_full, w_empty, w_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                brr_dec_pkg::CFG_P1_MUL_F1: n_cfg.p1_mul_f1 = i_cfg_data;
                brr_dec_pkg::CFG_P1_MUL_F2: n_cfg.p1_mul_f2 = i_cfg_data;
                brr_dec_pkg::CFG_P1_MUL_F3: n_cfg.p1_mul_f3 = i_cfg_data;
                brr_dec_pkg::CFG_P1_SH_F1:  n_cfg.p1_sh_f1  = i_cfg_data[3:0];
                brr_dec_pkg::CFG_P1_SH_F2:  n_cfg.p1_sh_f2  = i_cfg_data[3:0];
                brr_dec_pkg::CFG_P1_SH_F3:  n_cfg.p1_sh_f3  = i_cfg_data[3:0];
                brr_dec_pkg::CFG_P2_MUL_F2: n_cfg.p2_mul_f2 = i_cfg_data;
                brr_dec_pkg::CFG_P2_MUL_F3: n_cfg.p2_mul_f3 = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p1_mul_f1 <= 8'd15;
            r_cfg.p1_mul_f2 <= 8'd61;
            r_cfg.p1_mul_f3 <= 8'd115;
            r_cfg.p1_sh_f1  <= 4'd4;
            r_cfg.p1_sh_f2  <= 4'd5;
            r_cfg.p1_sh_f3  <= 4'd6;
            r_cfg.p2_mul_f2 <= 8'd15;
            r_cfg.p2_mul_f3 <= 8'd13;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    brr_dec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser[0]),
        .i_full   (w_full),
        .o_push   (w_push)
    );

    brr_dec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_blk   (w_qblk)
    );

    brr_dec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_empty),
        .i_blk    (w_qblk),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

// ===== hdl/brr_dec_fifo.sv =====
// ----------------------------------------------------------------------------
// BRR block queue
// Short register queue of accepted blocks between front and back.
// ----------------------------------------------------------------------------
module brr_dec_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brr_dec_pkg::t_push  i_push,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output brr_dec_pkg::t_blk   o_blk
);

    brr_dec_pkg::t_blk                     r_mem [brr_dec_pkg::QUEUE_DEPTH];
    logic [brr_dec_pkg::PTR_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic [brr_dec_pkg::PTR_W-1:0]         r_rd_ptr, n_rd_ptr;
    logic [brr_dec_pkg::CNT_W-1:0]         r_count,  n_count;

    assign o_full  = (r_count == brr_dec_pkg::CNT_W'(brr_dec_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_blk   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = brr_dec_pkg::PTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = brr_dec_pkg::PTR_W'(r_rd_ptr + 1'b1);
        end
        case ({i_push.valid, i_pop})
            2'b10:   n_count = brr_dec_pkg::CNT_W'(r_count + 1'b1);
            2'b01:   n_count = brr_dec_pkg::CNT_W'(r_count - 1'b1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.blk;
        end
    end

endmodule

// ===== hdl/brr_dec_front.sv =====
// ----------------------------------------------------------------------------
// BRR decoder front end
// Accepts blocks, tracks the finished-stream flag and drops blocks that
// arrive after an end-flagged block until a new stream starts.
// ----------------------------------------------------------------------------
module brr_dec_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_tvalid,
    output logic                                  o_tready,
    input  logic [brr_dec_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  logic                                  i_tuser,
    input  logic                                  i_full,
    output brr_dec_pkg::t_push                    o_push
);

    logic r_fin, n_fin;
    logic w_accept;
    logic w_end;

    assign o_tready = !i_full;
    assign w_accept = i_tvalid && o_tready;
    assign w_end    = i_tdata[brr_dec_pkg::HDR_END_BIT];

    always_comb begin
        o_push.blk.start  = i_tuser;
        o_push.blk.header = i_tdata[7:0];
        o_push.blk.data   = i_tdata[brr_dec_pkg::IN_TDATA_W-1:8];
        // a finished stream swallows blocks until one carries a start
        o_push.valid      = w_accept && (i_tuser || !r_fin);
        n_fin             = r_fin;
        if (w_accept) begin
            n_fin = (i_tuser ? 1'b0 : r_fin) | w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
        end else begin
            r_fin <= n_fin;
        end
    end

endmodule

// ===== hdl/brr_dec_back.sv =====
// ----------------------------------------------------------------------------
// BRR decoder back end
// Decodes one queued block into 16 samples, one per cycle unless stalled,
// through the predictor and clamp, into a registered output stage.
// ----------------------------------------------------------------------------
`include "brr_adpcm_block_decoder_defines.svh"

module brr_dec_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  brr_dec_pkg::t_cfg  i_cfg,
    input  logic               i_empty,
    input  brr_dec_pkg::t_blk  i_blk,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [15:0]        o_tdata,
    output logic               o_tlast,
    output logic [1:0]         o_tuser
);

    logic                           r_busy, n_busy;
    logic [brr_dec_pkg::IDX_W-1:0]  r_idx,  n_idx;
    logic signed [15:0]             r_prev1, n_prev1;
    logic signed [15:0]             r_prev2, n_prev2;
    logic                           r_out_valid, n_out_valid;
    brr_dec_pkg::t_blk              r_blk;
    logic signed [15:0]             r_out_pcm;
    logic                           r_out_last;
    logic [1:0]                     r_out_user;

    logic               w_adv, w_step, w_final, w_pop, w_last;
    logic [7:0]         w_byte;
    logic [3:0]         w_nib;
    logic [3:0]         w_range;
    logic [1:0]         w_filt;
    logic [7:0]         w_m1, w_m2;
    logic [3:0]         w_sh1;
    logic signed [18:0] w_scaled;
    logic signed [24:0] w_prod1, w_prod2;
    logic signed [24:0] w_term1, w_term2;
    logic signed [25:0] w_sum;
    logic signed [15:0] w_sample;

    assign w_adv   = !r_out_valid || i_tready;
    assign w_step  = r_busy && w_adv;
    assign w_last  = (r_idx == brr_dec_pkg::IDX_W'(brr_dec_pkg::SAMPLES - 1));
    assign w_final = w_step && w_last;
    // next block loads in the cycle the last sample leaves
    assign w_pop   = !i_empty && (!r_busy || w_final);
    assign o_pop   = w_pop;

    assign w_byte  = r_blk.data[r_idx[brr_dec_pkg::IDX_W-1:1]];
    assign w_nib   = r_idx[0] ? w_byte[3:0] : w_byte[7:4];
    assign w_range = r_blk.header[7:4];
    assign w_filt  = r_blk.header[3:2];

    always_comb begin
        unique case (w_filt)
            brr_dec_pkg::FILT_NONE: begin
                w_m1 = '0; w_sh1 = '0; w_m2 = '0;
            end
            brr_dec_pkg::FILT_1: begin
                w_m1 = i_cfg.p1_mul_f1; w_sh1 = i_cfg.p1_sh_f1; w_m2 = '0;
            end
            brr_dec_pkg::FILT_2: begin
                w_m1 = i_cfg.p1_mul_f2; w_sh1 = i_cfg.p1_sh_f2; w_m2 = i_cfg.p2_mul_f2;
            end
            brr_dec_pkg::FILT_3: begin
                w_m1 = i_cfg.p1_mul_f3; w_sh1 = i_cfg.p1_sh_f3; w_m2 = i_cfg.p2_mul_f3;
            end
            default: begin
                w_m1 = '0; w_sh1 = '0; w_m2 = '0;
            end
        endcase
    end

    always_comb begin
        w_scaled = 19'($signed(w_nib)) <<< w_range;
        w_prod1  = 25'(r_prev1) * 25'($signed({1'b0, w_m1}));
        w_prod2  = 25'(r_prev2) * 25'($signed({1'b0, w_m2}));
        w_term1  = w_prod1 >>> w_sh1;
        w_term2  = w_prod2 >>> brr_dec_pkg::PRED2_SHIFT;
        w_sum    = 26'(w_scaled) + 26'(w_term1) - 26'(w_term2);
        if (w_sum > 26'(brr_dec_pkg::PCM_MAX)) begin
            w_sample = brr_dec_pkg::PCM_MAX;
        end else if (w_sum < 26'(brr_dec_pkg::PCM_MIN)) begin
            w_sample = brr_dec_pkg::PCM_MIN;
        end else begin
            w_sample = 16'(w_sum);
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_prev1     = r_prev1;
        n_prev2     = r_prev2;
        n_out_valid = r_out_valid;
        if (w_step) begin
            n_idx       = brr_dec_pkg::IDX_W'(r_idx + 1'b1);
            n_prev2     = r_prev1;
            n_prev1     = w_sample;
            n_out_valid = 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end else if (i_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
            if (i_blk.start) begin
                n_prev1 = '0;
                n_prev2 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_prev1     <= '0;
            r_prev2     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_prev1     <= n_prev1;
            r_prev2     <= n_prev2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_blk <= i_blk;
        end
        if (w_step) begin
            r_out_pcm                       <= w_sample;
            r_out_last                      <= w_last;
            r_out_user[brr_dec_pkg::USER_END] <=
                w_last && r_blk.header[brr_dec_pkg::HDR_END_BIT];
            r_out_user[brr_dec_pkg::USER_LOOP] <=
                w_last && r_blk.header[brr_dec_pkg::HDR_END_BIT]
                       && r_blk.header[brr_dec_pkg::HDR_LOOP_BIT];
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_pcm;
    assign o_tlast  = r_out_last;
    assign o_tuser  = r_out_user;

    `BRR_ASSERT_NXT(a_final_is_last, i_clk, i_rst_n, w_final,
        o_tvalid && o_tlast, "sixteenth sample lacks tlast")
    `BRR_ASSERT_IMP(a_flags_on_last, i_clk, i_rst_n,
        r_out_valid && (r_out_user != 2'b00), r_out_last,
        "end or loop flag off the last sample")
    `BRR_ASSERT_IMP(a_loop_needs_end, i_clk, i_rst_n,
        r_out_valid && r_out_user[brr_dec_pkg::USER_LOOP],
        r_out_user[brr_dec_pkg::USER_END], "loop flag without end flag")
    `BRR_ASSERT_NXT(a_start_clears, i_clk, i_rst_n, w_pop && i_blk.start,
        r_busy && (r_idx == '0) && (r_prev1 == '0) && (r_prev2 == '0),
        "stream start did not clear history")

endmodule
